>>> hdl/lobmm_pkg.sv
// ----------------------------------------------------------------------------
// lobmm_pkg
// Shared types and constants for the limit order book with market maker.
// ----------------------------------------------------------------------------
package lobmm_pkg;

    // Order ids reserved for the maker's own quotes.
    localparam logic [15:0] QUOTE_BID_ID = 16'd999;
    localparam logic [15:0] QUOTE_ASK_ID = 16'd1000;

    // Result kinds.
    localparam logic [1:0] KIND_TRADE  = 2'd0;
    localparam logic [1:0] KIND_CANCEL = 2'd1;
    localparam logic [1:0] KIND_REST   = 2'd2;
    localparam logic [1:0] KIND_DONE   = 2'd3;

    // Result status codes.
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;

    // Configuration register indexes.
    localparam int          CFG_IDX_W     = 3;
    localparam logic [2:0]  CFG_MAX_INV   = 3'd0;
    localparam logic [2:0]  CFG_QSIZE     = 3'd1;
    localparam logic [2:0]  CFG_HSPREAD   = 3'd2;
    localparam logic [2:0]  CFG_GAIN      = 3'd3;
    localparam logic [2:0]  CFG_SKEW      = 3'd4;

    // Configuration reset values.
    localparam logic [14:0] RST_MAX_INV = 15'd100;
    localparam logic [15:0] RST_QSIZE   = 16'd5;
    localparam logic [23:0] RST_HSPREAD = 24'd65536;
    localparam logic [15:0] RST_GAIN    = 16'd26214;
    localparam logic [15:0] RST_SKEW    = 16'd6554;

    // At most this many results precede the completion of one order.
    localparam logic [5:0] OCNT_CAP = 6'd63;

    // One resting order.
    typedef struct packed {
        logic [15:0] id;
        logic [15:0] qty;
        logic [31:0] price;
    } t_entry;

    // Which order is currently being matched.
    typedef enum logic [1:0] {
        PH_EXT,
        PH_BID,
        PH_ASK
    } t_phase;

    // Datapath commands.
    typedef enum logic [4:0] {
        OP_NONE,
        OP_ACCEPT,
        OP_SCAN,
        OP_NEXTQ,
        OP_TAKE,
        OP_MISS,
        OP_TRADE,
        OP_DROP,
        OP_FULL,
        OP_POS_START,
        OP_STEP,
        OP_INSERT,
        OP_LVL_START,
        OP_LVL_STEP,
        OP_LVL_SIDE,
        OP_DIV_START,
        OP_DIV_STEP,
        OP_PRICE,
        OP_LOAD_BID,
        OP_LOAD_ASK,
        OP_DONE
    } t_op;

    // Controller states.
    typedef enum logic [4:0] {
        S_IDLE,
        S_DISPATCH,
        S_SCAN,
        S_TAKE,
        S_MISS,
        S_MATCH,
        S_TRADE,
        S_FULL,
        S_POS,
        S_INSERT,
        S_AFTER,
        S_RQ,
        S_LVL,
        S_DIV,
        S_PRICE,
        S_QBID,
        S_QASK,
        S_DONE
    } t_state;

    // Datapath status towards the controller.
    typedef struct packed {
        logic   out_free;
        logic   emit_ok;
        logic   hit;
        logic   scan_end;
        logic   side1;
        logic   is_cancel;
        logic   below_quote;
        logic   target_bid;
        logic   can_trade;
        logic   rem_zero;
        logic   is_market;
        logic   side_full;
        logic   pos_stop;
        logic   lvl_end;
        logic   quote_ok;
        logic   div_done;
        logic   bid_ok;
        logic   ask_ok;
        t_phase phase;
    } t_dp_stat;

endpackage

>>> hdl/limit_order_book_market_maker_top.sv
// ----------------------------------------------------------------------------
// limit_order_book_market_maker_top
// Price-time priority bid and ask books with an inventory-aware quoting maker.
// ----------------------------------------------------------------------------
// Orders enter on the i_valid/o_ready channel, one transaction per order or
// cancel. Results leave on the o_valid/i_ready channel; each input produces
// one or more results, the final one flagged by o_last. Configuration
// registers are written on the i_cfg_valid/o_cfg_ready channel, which is
// always ready; write only while the block is idle.
// One order is processed at a time. A cancel walks both books one entry per
// cycle and registers its result once it finds the id or reaches the end.
// An add walks the books for quote withdrawal, matches resting orders one at
// a time, walks one entry per cycle to find its insertion point, and when it
// requotes it sums the best levels one entry per cycle and runs a restoring
// divider of 16+$clog2(BOOK_DEPTH+1)+16 steps (37 at the default depth).
// A result occupies the output register until taken; a stalled receiver holds
// the sequencer at its next result; non-final ones past OCNT_CAP are dropped.
// Reset clears both books, the inventory and the output valid, and loads the
// configuration defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
module limit_order_book_market_maker_top
    import lobmm_pkg::*;
#(
    parameter int BOOK_DEPTH = 16
)(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic                 i_func,
    input  logic [15:0]          i_order_id,
    input  logic                 i_order_kind,
    input  logic                 i_order_side,
    input  logic [31:0]          i_limit_price,
    input  logic [15:0]          i_order_qty,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [23:0]          i_cfg_data,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [1:0]           o_kind,
    output logic [15:0]          o_taker_id,
    output logic [15:0]          o_maker_id,
    output logic [15:0]          o_fill_qty,
    output logic [31:0]          o_fill_price,
    output logic                 o_book_side,
    output logic signed [15:0]   o_inventory,
    output logic [1:0]           o_status,
    output logic                 o_last
);

    t_op      w_op;
    t_dp_stat w_stat;

    assign o_cfg_ready = 1'b1;

    // Sequencer.
    lobmm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_stat  (w_stat),
        .o_op    (w_op)
    );

    // Books, arithmetic and output register.
    lobmm_dp #(
        .BOOK_DEPTH (BOOK_DEPTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_op          (w_op),
        .o_stat        (w_stat),
        .i_func        (i_func),
        .i_order_id    (i_order_id),
        .i_order_kind  (i_order_kind),
        .i_order_side  (i_order_side),
        .i_limit_price (i_limit_price),
        .i_order_qty   (i_order_qty),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_kind        (o_kind),
        .o_taker_id    (o_taker_id),
        .o_maker_id    (o_maker_id),
        .o_fill_qty    (o_fill_qty),
        .o_fill_price  (o_fill_price),
        .o_book_side   (o_book_side),
        .o_inventory   (o_inventory),
        .o_status      (o_status),
        .o_last        (o_last)
    );

endmodule

>>> hdl/lobmm_ctrl.sv
// ----------------------------------------------------------------------------
// lobmm_ctrl
// Sequencer for cancels, withdrawals, matching, insertion and requoting.
// ----------------------------------------------------------------------------
module lobmm_ctrl
    import lobmm_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_dp_stat i_stat,
    output t_op      o_op
);

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and datapath command.
    always_comb begin
        n_state = r_state;
        o_op    = OP_NONE;
        o_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_op    = OP_ACCEPT;
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (i_stat.is_cancel || i_stat.below_quote) begin
                    n_state = S_SCAN;
                end else begin
                    n_state = S_MATCH;
                end
            end
            S_SCAN: begin
                if (i_stat.hit) begin
                    n_state = S_TAKE;
                end else if (i_stat.scan_end && i_stat.side1) begin
                    if (i_stat.is_cancel) begin
                        n_state = S_MISS;
                    end else begin
                        o_op    = OP_NEXTQ;
                        n_state = i_stat.target_bid ? S_SCAN : S_MATCH;
                    end
                end else begin
                    o_op = OP_SCAN;
                end
            end
            S_TAKE: begin
                if (i_stat.emit_ok) begin
                    o_op = OP_TAKE;
                    if (i_stat.is_cancel) begin
                        n_state = S_IDLE;
                    end else begin
                        n_state = i_stat.target_bid ? S_SCAN : S_MATCH;
                    end
                end
            end
            S_MISS: begin
                if (i_stat.out_free) begin
                    o_op    = OP_MISS;
                    n_state = S_IDLE;
                end
            end
            S_MATCH: begin
                if (i_stat.can_trade) begin
                    n_state = S_TRADE;
                end else if (i_stat.rem_zero) begin
                    n_state = S_AFTER;
                end else if (i_stat.is_market) begin
                    o_op    = OP_DROP;
                    n_state = S_AFTER;
                end else if (i_stat.side_full) begin
                    n_state = S_FULL;
                end else begin
                    o_op    = OP_POS_START;
                    n_state = S_POS;
                end
            end
            S_TRADE: begin
                if (i_stat.emit_ok) begin
                    o_op    = OP_TRADE;
                    n_state = S_MATCH;
                end
            end
            S_FULL: begin
                if (i_stat.emit_ok) begin
                    o_op    = OP_FULL;
                    n_state = S_AFTER;
                end
            end
            S_POS: begin
                if (i_stat.pos_stop) begin
                    n_state = S_INSERT;
                end else begin
                    o_op = OP_STEP;
                end
            end
            S_INSERT: begin
                if (i_stat.emit_ok) begin
                    o_op    = OP_INSERT;
                    n_state = S_AFTER;
                end
            end
            S_AFTER: begin
                unique case (i_stat.phase)
                    PH_EXT:  n_state = i_stat.below_quote ? S_RQ : S_DONE;
                    PH_BID:  n_state = S_QASK;
                    default: n_state = S_DONE;
                endcase
            end
            S_RQ: begin
                if (i_stat.quote_ok) begin
                    o_op    = OP_LVL_START;
                    n_state = S_LVL;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_LVL: begin
                if (i_stat.lvl_end) begin
                    if (i_stat.side1) begin
                        o_op    = OP_DIV_START;
                        n_state = S_DIV;
                    end else begin
                        o_op = OP_LVL_SIDE;
                    end
                end else begin
                    o_op = OP_LVL_STEP;
                end
            end
            S_DIV: begin
                if (i_stat.div_done) begin
                    n_state = S_PRICE;
                end else begin
                    o_op = OP_DIV_STEP;
                end
            end
            S_PRICE: begin
                o_op    = OP_PRICE;
                n_state = S_QBID;
            end
            S_QBID: begin
                if (i_stat.bid_ok) begin
                    o_op    = OP_LOAD_BID;
                    n_state = S_MATCH;
                end else begin
                    n_state = S_QASK;
                end
            end
            S_QASK: begin
                if (i_stat.ask_ok) begin
                    o_op    = OP_LOAD_ASK;
                    n_state = S_MATCH;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_op    = OP_DONE;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

>>> hdl/lobmm_dp.sv
// ----------------------------------------------------------------------------
// lobmm_dp
// Book storage, configuration, matching arithmetic, quote pricing divider
// and the output register.
// ----------------------------------------------------------------------------
module lobmm_dp
    import lobmm_pkg::*;
#(
    parameter int BOOK_DEPTH = 16
)(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_op                  i_op,
    output t_dp_stat             o_stat,
    input  logic                 i_func,
    input  logic [15:0]          i_order_id,
    input  logic                 i_order_kind,
    input  logic                 i_order_side,
    input  logic [31:0]          i_limit_price,
    input  logic [15:0]          i_order_qty,
    input  logic                 i_cfg_valid,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [23:0]          i_cfg_data,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [1:0]           o_kind,
    output logic [15:0]          o_taker_id,
    output logic [15:0]          o_maker_id,
    output logic [15:0]          o_fill_qty,
    output logic [31:0]          o_fill_price,
    output logic                 o_book_side,
    output logic signed [15:0]   o_inventory,
    output logic [1:0]           o_status,
    output logic                 o_last
);

    localparam int D  = BOOK_DEPTH;
    localparam int IW = $clog2(D);
    localparam int CW = $clog2(D + 1);
    localparam int LW = 16 + CW;
    localparam int DW = LW + 2;
    localparam int NW = LW + 16;
    localparam int KW = $clog2(NW + 1);

    // Configuration registers.
    logic [14:0] r_max_inv;
    logic [15:0] r_qsize;
    logic [23:0] r_hspread;
    logic [15:0] r_gain;
    logic [15:0] r_spu;

    // Incoming order and the order being matched.
    logic        r_func;
    logic [15:0] r_ext_id;
    logic [15:0] r_dropped;
    logic        r_full;
    logic [15:0] r_cur_id;
    logic        r_cur_side;
    logic        r_cur_mkt;
    logic [31:0] r_cur_price;
    logic [15:0] r_cur_qty;
    t_phase      r_phase;
    logic [15:0] r_target;

    // Walk pointer over one book.
    logic          r_side;
    logic [CW-1:0] r_idx;

    // Books and their entry counts.
    t_entry        r_book [2][D];
    logic [CW-1:0] r_cnt  [2];

    logic signed [15:0] r_inv;
    logic [5:0]         r_ocnt;

    // Quote pricing.
    logic [LW-1:0]      r_bq;
    logic [LW-1:0]      r_aq;
    logic [31:0]        r_mid;
    logic               r_bq_ge;
    logic [NW-1:0]      r_num;
    logic [DW:0]        r_rem;
    logic [DW-1:0]      r_den;
    logic [KW-1:0]      r_dcnt;
    logic signed [32:0] r_skew;
    logic [31:0]        r_bidp;
    logic [31:0]        r_askp;

    // Output register.
    logic        r_ovalid;
    logic [1:0]  r_kind;
    logic [15:0] r_taker;
    logic [15:0] r_maker;
    logic [15:0] r_fqty;
    logic [31:0] r_fprice;
    logic        r_fside;
    logic [15:0] r_finv;
    logic [1:0]  r_fstatus;
    logic        r_flast;

    // Combinational helpers.
    t_entry        w_ent;
    t_entry        w_m;
    logic          w_opp;
    logic [15:0]   w_t;
    logic          w_cap;
    logic          w_out_free;
    logic          w_scan_end;
    logic          w_price_ok;
    logic [17:0]   w_inv_sum;
    logic [15:0]   w_inv_trade;
    logic [32:0]   w_best_sum;
    logic [LW-1:0] w_mag;
    logic [DW-1:0] w_den;
    logic [DW:0]   w_rem_sh;
    logic [15:0]   w_q;
    logic [35:0]   w_fair;
    logic [35:0]   w_bidv;
    logic [35:0]   w_askv;
    logic [16:0]   w_inv17;
    logic [16:0]   w_max17;

    // Book write controls and the result to load.
    logic [1:0]    w_rm_en;
    logic [IW-1:0] w_rm_idx;
    logic [1:0]    w_ins_en;
    t_entry        w_ins_ent;
    logic [1:0]    w_upd0;
    logic [15:0]   w_upd_qty;
    logic          w_put;
    logic          w_do_put;
    logic [1:0]    n_kind;
    logic [15:0]   n_taker;
    logic [15:0]   n_maker;
    logic [15:0]   n_fqty;
    logic [31:0]   n_fprice;
    logic          n_fside;
    logic [1:0]    n_fstatus;
    logic          n_flast;
    logic [15:0]   n_inv;

    // Reads at the walk pointer and at the head of the opposite book.
    assign w_ent      = r_book[r_side][r_idx[IW-1:0]];
    assign w_opp      = ~r_cur_side;
    assign w_m        = r_book[w_opp][0];
    assign w_t        = (r_cur_qty < w_m.qty) ? r_cur_qty : w_m.qty;
    assign w_cap      = (r_ocnt == OCNT_CAP);
    assign w_out_free = !r_ovalid || i_ready;
    assign w_scan_end = (r_idx >= r_cnt[r_side]);
    assign w_price_ok = r_cur_mkt ||
                        (r_cur_side ? (w_m.price >= r_cur_price) : (w_m.price <= r_cur_price));

    // Saturating inventory change of a maker quote fill.
    assign w_inv_sum = w_opp ? ({{2{r_inv[15]}}, r_inv} - {2'b00, w_t})
                             : ({{2{r_inv[15]}}, r_inv} + {2'b00, w_t});
    always_comb begin
        if (w_inv_sum[17] && !(&w_inv_sum[16:15])) begin
            w_inv_trade = 16'h8000;
        end else if (!w_inv_sum[17] && (|w_inv_sum[16:15])) begin
            w_inv_trade = 16'h7FFF;
        end else begin
            w_inv_trade = w_inv_sum[15:0];
        end
    end

    // Pricing arithmetic.
    assign w_best_sum = {1'b0, r_book[0][0].price} + {1'b0, r_book[1][0].price};
    assign w_mag      = (r_bq >= r_aq) ? (r_bq - r_aq) : (r_aq - r_bq);
    assign w_den      = {({1'b0, r_bq} + {1'b0, r_aq}), 1'b0};
    assign w_rem_sh   = {r_rem[DW-1:0], r_num[NW-1]};
    assign w_q        = (r_den == '0) ? 16'd0 : r_num[15:0];
    assign w_fair     = r_bq_ge ? ({4'd0, r_mid} + {20'd0, w_q})
                                : ({4'd0, r_mid} - {20'd0, w_q});
    assign w_bidv     = w_fair - {12'd0, r_hspread} - {{3{r_skew[32]}}, r_skew};
    assign w_askv     = w_fair + {12'd0, r_hspread} - {{3{r_skew[32]}}, r_skew};
    assign w_inv17    = {r_inv[15], r_inv};
    assign w_max17    = {2'b00, r_max_inv};

    // Status towards the controller.
    always_comb begin
        o_stat.out_free    = w_out_free;
        o_stat.emit_ok     = w_out_free || w_cap;
        o_stat.hit         = !w_scan_end && (w_ent.id == r_target);
        o_stat.scan_end    = w_scan_end;
        o_stat.side1       = r_side;
        o_stat.is_cancel   = r_func;
        o_stat.below_quote = (r_ext_id < QUOTE_BID_ID);
        o_stat.target_bid  = (r_target == QUOTE_BID_ID);
        o_stat.can_trade   = (r_cur_qty != 16'd0) && (r_cnt[w_opp] != '0) && w_price_ok;
        o_stat.rem_zero    = (r_cur_qty == 16'd0);
        o_stat.is_market   = r_cur_mkt;
        o_stat.side_full   = (r_cnt[r_cur_side] == CW'(D));
        o_stat.pos_stop    = w_scan_end ||
                             (r_side ? (w_ent.price > r_cur_price) : (w_ent.price < r_cur_price));
        o_stat.lvl_end     = w_scan_end || (w_ent.price != r_book[r_side][0].price);
        o_stat.quote_ok    = (r_cnt[0] != '0) && (r_cnt[1] != '0) && (w_best_sum != 33'd0);
        o_stat.div_done    = (r_dcnt == '0);
        o_stat.bid_ok      = $signed(w_inv17) < $signed(w_max17);
        o_stat.ask_ok      = $signed(w_inv17) > -$signed(w_max17);
        o_stat.phase       = r_phase;
    end

    // Book edits and the result produced by each command.
    always_comb begin
        w_rm_en   = 2'b00;
        w_rm_idx  = '0;
        w_ins_en  = 2'b00;
        w_ins_ent = '{id: r_cur_id, qty: r_cur_qty, price: r_cur_price};
        w_upd0    = 2'b00;
        w_upd_qty = w_m.qty - w_t;
        w_put     = 1'b0;
        n_kind    = KIND_DONE;
        n_taker   = r_cur_id;
        n_maker   = 16'd0;
        n_fqty    = 16'd0;
        n_fprice  = 32'd0;
        n_fside   = 1'b0;
        n_fstatus = ST_OK;
        n_flast   = 1'b0;
        n_inv     = r_inv;
        case (i_op)
            OP_TAKE: begin
                w_rm_en[r_side] = 1'b1;
                w_rm_idx        = r_idx[IW-1:0];
                w_put           = 1'b1;
                n_kind          = KIND_CANCEL;
                n_taker         = r_target;
                n_fqty          = w_ent.qty;
                n_fprice        = w_ent.price;
                n_fside         = r_side;
                n_flast         = r_func;
            end
            OP_MISS: begin
                w_put     = 1'b1;
                n_kind    = KIND_CANCEL;
                n_taker   = r_target;
                n_fstatus = ST_NOT_FOUND;
                n_flast   = 1'b1;
            end
            OP_TRADE: begin
                if (w_t == w_m.qty) begin
                    w_rm_en[w_opp] = 1'b1;
                end else begin
                    w_upd0[w_opp] = 1'b1;
                end
                if (w_m.id == QUOTE_BID_ID || w_m.id == QUOTE_ASK_ID) begin
                    n_inv = w_inv_trade;
                end
                w_put    = 1'b1;
                n_kind   = KIND_TRADE;
                n_maker  = w_m.id;
                n_fqty   = w_t;
                n_fprice = w_m.price;
                n_fside  = w_opp;
            end
            OP_FULL: begin
                w_put     = 1'b1;
                n_kind    = KIND_REST;
                n_fqty    = r_cur_qty;
                n_fprice  = r_cur_price;
                n_fside   = r_cur_side;
                n_fstatus = ST_FULL;
            end
            OP_INSERT: begin
                w_ins_en[r_cur_side] = 1'b1;
                w_put                = 1'b1;
                n_kind               = KIND_REST;
                n_fqty               = r_cur_qty;
                n_fprice             = r_cur_price;
                n_fside              = r_cur_side;
            end
            OP_DONE: begin
                w_put     = 1'b1;
                n_kind    = KIND_DONE;
                n_taker   = r_ext_id;
                n_fqty    = r_dropped;
                n_fstatus = r_full ? ST_FULL : ST_OK;
                n_flast   = 1'b1;
            end
            default: ;
        endcase
        w_do_put = w_put && (n_flast || !w_cap);
    end

    // Book entries: removal closes the gap, insertion opens one.
    for (genvar s = 0; s < 2; s++) begin : g_side
        for (genvar j = 0; j < D; j++) begin : g_ent
            always_ff @(posedge i_clk) begin
                if (w_rm_en[s]) begin
                    if (j < D - 1) begin
                        if (IW'(j) >= w_rm_idx) begin
                            r_book[s][j] <= r_book[s][(j < D - 1) ? j + 1 : j];
                        end
                    end
                end else if (w_ins_en[s]) begin
                    if (IW'(j) == r_idx[IW-1:0]) begin
                        r_book[s][j] <= w_ins_ent;
                    end else if (j > 0) begin
                        if (IW'(j) > r_idx[IW-1:0]) begin
                            r_book[s][j] <= r_book[s][(j > 0) ? j - 1 : j];
                        end
                    end
                end else if (w_upd0[s] && j == 0) begin
                    r_book[s][j].qty <= w_upd_qty;
                end
            end
        end
    end

    // Control state: counts, inventory, output valid and configuration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt[0]  <= '0;
            r_cnt[1]  <= '0;
            r_inv     <= '0;
            r_ovalid  <= 1'b0;
            r_max_inv <= RST_MAX_INV;
            r_qsize   <= RST_QSIZE;
            r_hspread <= RST_HSPREAD;
            r_gain    <= RST_GAIN;
            r_spu     <= RST_SKEW;
        end else begin
            for (int s = 0; s < 2; s++) begin
                if (w_rm_en[s]) begin
                    r_cnt[s] <= r_cnt[s] - CW'(1);
                end else if (w_ins_en[s]) begin
                    r_cnt[s] <= r_cnt[s] + CW'(1);
                end
            end
            r_inv <= n_inv;
            if (w_do_put) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_MAX_INV: r_max_inv <= i_cfg_data[14:0];
                    CFG_QSIZE:   r_qsize   <= i_cfg_data[15:0];
                    CFG_HSPREAD: r_hspread <= i_cfg_data;
                    CFG_GAIN:    r_gain    <= i_cfg_data[15:0];
                    CFG_SKEW:    r_spu     <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
        end
    end

    // Order, walk pointer and pricing registers.
    always_ff @(posedge i_clk) begin
        case (i_op)
            OP_ACCEPT: begin
                r_func      <= i_func;
                r_ext_id    <= i_order_id;
                r_cur_id    <= i_order_id;
                r_cur_side  <= i_order_side;
                r_cur_mkt   <= i_order_kind;
                r_cur_price <= i_limit_price;
                r_cur_qty   <= i_order_qty;
                r_phase     <= PH_EXT;
                r_target    <= i_func ? i_order_id : QUOTE_BID_ID;
                r_side      <= 1'b0;
                r_idx       <= '0;
                r_ocnt      <= '0;
                r_dropped   <= '0;
                r_full      <= 1'b0;
            end
            OP_SCAN: begin
                if (!r_side && w_scan_end) begin
                    r_side <= 1'b1;
                    r_idx  <= '0;
                end else begin
                    r_idx <= r_idx + CW'(1);
                end
            end
            OP_NEXTQ, OP_TAKE: begin
                if (!r_func && r_target == QUOTE_BID_ID) begin
                    r_target <= QUOTE_ASK_ID;
                    r_side   <= 1'b0;
                    r_idx    <= '0;
                end
            end
            OP_TRADE: r_cur_qty <= r_cur_qty - w_t;
            OP_DROP: begin
                if (r_phase == PH_EXT) begin
                    r_dropped <= r_cur_qty;
                end
            end
            OP_FULL: begin
                if (r_phase == PH_EXT) begin
                    r_dropped <= r_cur_qty;
                    r_full    <= 1'b1;
                end
            end
            OP_POS_START: begin
                r_side <= r_cur_side;
                r_idx  <= '0;
            end
            OP_STEP: r_idx <= r_idx + CW'(1);
            OP_LVL_START: begin
                r_side <= 1'b0;
                r_idx  <= '0;
                r_bq   <= '0;
                r_aq   <= '0;
                r_mid  <= w_best_sum[32:1];
            end
            OP_LVL_STEP: begin
                if (r_side) begin
                    r_aq <= r_aq + LW'(w_ent.qty);
                end else begin
                    r_bq <= r_bq + LW'(w_ent.qty);
                end
                r_idx <= r_idx + CW'(1);
            end
            OP_LVL_SIDE: begin
                r_side <= 1'b1;
                r_idx  <= '0;
            end
            OP_DIV_START: begin
                r_num   <= NW'(w_mag) * NW'(r_gain);
                r_den   <= w_den;
                r_rem   <= '0;
                r_dcnt  <= KW'(NW);
                r_bq_ge <= (r_bq >= r_aq);
                r_skew  <= 33'(r_inv) * 33'($signed({1'b0, r_spu}));
            end
            OP_DIV_STEP: begin
                // One restoring step: one quotient bit per cycle.
                if (w_rem_sh >= {1'b0, r_den}) begin
                    r_rem <= w_rem_sh - {1'b0, r_den};
                    r_num <= {r_num[NW-2:0], 1'b1};
                end else begin
                    r_rem <= w_rem_sh;
                    r_num <= {r_num[NW-2:0], 1'b0};
                end
                r_dcnt <= r_dcnt - KW'(1);
            end
            OP_PRICE: begin
                r_bidp <= w_bidv[35] ? 32'd0 : ((|w_bidv[34:32]) ? 32'hFFFF_FFFF : w_bidv[31:0]);
                r_askp <= w_askv[35] ? 32'd0 : ((|w_askv[34:32]) ? 32'hFFFF_FFFF : w_askv[31:0]);
            end
            OP_LOAD_BID: begin
                r_cur_id    <= QUOTE_BID_ID;
                r_cur_side  <= 1'b0;
                r_cur_mkt   <= 1'b0;
                r_cur_price <= r_bidp;
                r_cur_qty   <= r_qsize;
                r_phase     <= PH_BID;
            end
            OP_LOAD_ASK: begin
                r_cur_id    <= QUOTE_ASK_ID;
                r_cur_side  <= 1'b1;
                r_cur_mkt   <= 1'b0;
                r_cur_price <= r_askp;
                r_cur_qty   <= r_qsize;
                r_phase     <= PH_ASK;
            end
            default: ;
        endcase
        if (w_do_put && !n_flast) begin
            r_ocnt <= r_ocnt + 6'd1;
        end
    end

    // Output payload register.
    always_ff @(posedge i_clk) begin
        if (w_do_put) begin
            r_kind    <= n_kind;
            r_taker   <= n_taker;
            r_maker   <= n_maker;
            r_fqty    <= n_fqty;
            r_fprice  <= n_fprice;
            r_fside   <= n_fside;
            r_finv    <= n_inv;
            r_fstatus <= n_fstatus;
            r_flast   <= n_flast;
        end
    end

    assign o_valid      = r_ovalid;
    assign o_kind       = r_kind;
    assign o_taker_id   = r_taker;
    assign o_maker_id   = r_maker;
    assign o_fill_qty   = r_fqty;
    assign o_fill_price = r_fprice;
    assign o_book_side  = r_fside;
    assign o_inventory  = r_finv;
    assign o_status     = r_fstatus;
    assign o_last       = r_flast;

endmodule
